FILE: rtl/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

   localparam logic [7:0]  POLL_MARK       = 8'h80;
   localparam logic [31:0] REQUEST_WAIT_US = 32'd4600;
   localparam logic [31:0] BYTE_GAP_US     = 32'd3000;

   localparam logic [7:0] SLOT0_ID_RESET = 8'd142;
   localparam logic [7:0] SLOT1_ID_RESET = 8'd141;
   localparam logic [7:0] SLOT2_ID_RESET = 8'h8A;
   localparam logic [7:0] SLOT3_ID_RESET = 8'h89;
   localparam logic [6:0] LENGTH_RESET   = 7'd45;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RX    = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CSR_SLOT0_ID     = 3'd0,
      CSR_SLOT1_ID     = 3'd1,
      CSR_SLOT2_ID     = 3'd2,
      CSR_SLOT3_ID     = 3'd3,
      CSR_SLOT0_LENGTH = 3'd4,
      CSR_SLOT1_LENGTH = 3'd5,
      CSR_SLOT2_LENGTH = 3'd6,
      CSR_SLOT3_LENGTH = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_us;
      logic [7:0]  rx_byte;
      logic [1:0]  write_slot;
      logic [5:0]  write_index;
      logic [7:0]  write_value;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       transmitter_on;
      logic       request_valid;
      logic [1:0] request_slot;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/telemetry_poll_responder_core.sv
// latency: a transaction is taken into the input register and its result goes out from the result register
// throughput: one transaction per cycle while the result side does not stall, set by the input and result registers
// the message store is prefetched from the next state, so a tick needs no wait on the read
// reset: synchronous, active high; clears the pipeline, the poll and reply state
// and restores the slot sensor ids and lengths; the message store is not cleared
`default_nettype none

module telemetry_poll_responder_core import tpr_pkg::*; #(
   parameter int SLOT_COUNT        = 4,
   parameter int MAX_MESSAGE_BYTES = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,
   input  wire logic          csr_write,
   input  wire logic [2:0]    csr_index,
   input  wire logic [7:0]    csr_wdata
);

   localparam int DEPTH = SLOT_COUNT * MAX_MESSAGE_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int LW    = $clog2(MAX_MESSAGE_BYTES + 2);

   function automatic logic [2:0] find_slot(input logic [7:0] key,
                                            input logic [3:0][7:0] ids);
      logic [2:0] res;
      res = 3'b000;
      for (int s = 0; s < 4; s++) begin
         if (s < SLOT_COUNT && !res[2] && ids[s] == key) begin
            res = {1'b1, 2'(s)};
         end
      end
      return res;
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic [1:0] slot,
                                               input logic [PW-1:0] pos);
      return AW'(32'(slot) * MAX_MESSAGE_BYTES + 32'(pos));
   endfunction

   // configuration
   logic [3:0][7:0] slot_id_ff, slot_id_in;
   logic [3:0][6:0] slot_len_ff, slot_len_in;

   // pipeline
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    out_free, process, req_accept;

   // poll and reply state
   logic [1:0]    rx_count_ff, rx_count_in;
   logic [7:0]    rx_first_ff, rx_first_in;
   logic [7:0]    rx_second_ff, rx_second_in;
   logic [31:0]   request_time_ff, request_time_in;
   logic          sending_ff, sending_in;
   logic [1:0]    active_slot_ff, active_slot_in;
   logic [LW-1:0] bytes_left_ff, bytes_left_in;
   logic [PW-1:0] byte_position_ff, byte_position_in;
   logic [7:0]    running_sum_ff, running_sum_in;
   logic [31:0]   last_send_time_ff, last_send_time_in;

   // store access
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    ram_rdata, rd_value;
   logic          fwd_hit_ff, fwd_hit_in;
   logic [7:0]    fwd_data_ff;
   logic [2:0]    pf_hit, tick_hit;

   // scratch for the tick path
   logic          start, go;
   logic [8:0]    len_wide, len_clamped;
   logic [LW-1:0] new_bytes_left;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign process    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      slot_id_in  = slot_id_ff;
      slot_len_in = slot_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SLOT0_ID:     slot_id_in[0]  = csr_wdata;
            CSR_SLOT1_ID:     slot_id_in[1]  = csr_wdata;
            CSR_SLOT2_ID:     slot_id_in[2]  = csr_wdata;
            CSR_SLOT3_ID:     slot_id_in[3]  = csr_wdata;
            CSR_SLOT0_LENGTH: slot_len_in[0] = csr_wdata[6:0];
            CSR_SLOT1_LENGTH: slot_len_in[1] = csr_wdata[6:0];
            CSR_SLOT2_LENGTH: slot_len_in[2] = csr_wdata[6:0];
            CSR_SLOT3_LENGTH: slot_len_in[3] = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign rd_value = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   assign tick_hit = find_slot(rx_second_ff, slot_id_ff);

   always_comb begin
      rx_count_in       = rx_count_ff;
      rx_first_in       = rx_first_ff;
      rx_second_in      = rx_second_ff;
      request_time_in   = request_time_ff;
      sending_in        = sending_ff;
      active_slot_in    = active_slot_ff;
      bytes_left_in     = bytes_left_ff;
      byte_position_in  = byte_position_ff;
      running_sum_in    = running_sum_ff;
      last_send_time_in = last_send_time_ff;
      rsp_data_in       = '0;
      wr_en             = 1'b0;
      wr_addr           = slot_addr(in_data_ff.write_slot, PW'(in_data_ff.write_index));
      start             = 1'b0;
      go                = 1'b0;
      len_wide          = {2'b00, slot_len_ff[tick_hit[1:0]]};
      len_clamped       = (len_wide > 9'(MAX_MESSAGE_BYTES)) ?
                          9'(MAX_MESSAGE_BYTES) : len_wide;
      new_bytes_left    = LW'(len_clamped) + LW'(1);

      if (process) begin
         unique case (in_data_ff.kind)
            KIND_RX: begin
               if (!sending_ff) begin
                  if (rx_count_ff == 2'd0) begin
                     rx_first_in = in_data_ff.rx_byte;
                  end else if (rx_count_ff == 2'd1) begin
                     rx_second_in = in_data_ff.rx_byte;
                  end
                  if (rx_count_ff != 2'd3) begin
                     rx_count_in = rx_count_ff + 2'd1;
                  end
               end
            end
            KIND_WRITE: begin
               wr_en = (32'(in_data_ff.write_slot) < SLOT_COUNT) &&
                       (32'(in_data_ff.write_index) < MAX_MESSAGE_BYTES);
            end
            KIND_TICK: begin
               // poll check
               if (!sending_ff && rx_count_ff[1]) begin
                  if (rx_count_ff == 2'd3) begin
                     rx_count_in     = 2'd0;
                     request_time_in = '0;
                  end else if (request_time_ff == '0) begin
                     request_time_in = in_data_ff.now_us;
                  end else if ((in_data_ff.now_us - request_time_ff) >= REQUEST_WAIT_US) begin
                     request_time_in = '0;
                     rx_count_in     = 2'd0;
                     if (rx_first_ff == POLL_MARK && tick_hit[2]) begin
                        start            = 1'b1;
                        active_slot_in   = tick_hit[1:0];
                        bytes_left_in    = new_bytes_left;
                        byte_position_in = '0;
                        rsp_data_in.request_valid = 1'b1;
                        rsp_data_in.request_slot  = tick_hit[1:0];
                     end
                  end
               end
               // reply byte
               if (sending_ff || start) begin
                  go = !(sending_ff &&
                         ((in_data_ff.now_us - last_send_time_ff) < BYTE_GAP_US));
                  if (go) begin
                     sending_in = 1'b1;
                     if (bytes_left_in == '0) begin
                        sending_in     = 1'b0;
                        running_sum_in = '0;
                        rx_count_in    = 2'd0;
                     end else begin
                        bytes_left_in        = bytes_left_in - LW'(1);
                        rsp_data_in.tx_valid = 1'b1;
                        if (bytes_left_in != '0) begin
                           running_sum_in      = running_sum_ff + rd_value;
                           rsp_data_in.tx_byte = rd_value;
                           if (byte_position_in < PW'(MAX_MESSAGE_BYTES)) begin
                              byte_position_in = byte_position_in + PW'(1);
                           end
                        end else begin
                           rsp_data_in.tx_byte = running_sum_ff;
                        end
                     end
                     last_send_time_in = in_data_ff.now_us;
                  end
               end
            end
            default: ;
         endcase
      end
      rsp_data_in.transmitter_on = sending_in;
   end

   // prefetch the byte the next tick may send: the current reply position,
   // or the first byte of the slot the pending poll would select
   assign pf_hit     = find_slot(rx_second_in, slot_id_in);
   assign rd_addr    = sending_in ? slot_addr(active_slot_in, byte_position_in)
                                  : slot_addr(pf_hit[1:0], '0);
   assign fwd_hit_in = wr_en && (wr_addr == rd_addr);

   assign in_valid_in  = req_accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = process ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   tpr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (wr_en),
      .write_address(wr_addr),
      .write_data   (in_data_ff.write_value),
      .read_address (rd_addr),
      .read_data    (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_id_ff        <= {SLOT3_ID_RESET, SLOT2_ID_RESET, SLOT1_ID_RESET, SLOT0_ID_RESET};
         slot_len_ff       <= {4{LENGTH_RESET}};
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         fwd_hit_ff        <= 1'b0;
         rx_count_ff       <= '0;
         rx_first_ff       <= '0;
         rx_second_ff      <= '0;
         request_time_ff   <= '0;
         sending_ff        <= 1'b0;
         active_slot_ff    <= '0;
         bytes_left_ff     <= '0;
         byte_position_ff  <= '0;
         running_sum_ff    <= '0;
         last_send_time_ff <= '0;
      end else begin
         slot_id_ff        <= slot_id_in;
         slot_len_ff       <= slot_len_in;
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         fwd_hit_ff        <= fwd_hit_in;
         rx_count_ff       <= rx_count_in;
         rx_first_ff       <= rx_first_in;
         rx_second_ff      <= rx_second_in;
         request_time_ff   <= request_time_in;
         sending_ff        <= sending_in;
         active_slot_ff    <= active_slot_in;
         bytes_left_ff     <= bytes_left_in;
         byte_position_ff  <= byte_position_in;
         running_sum_ff    <= running_sum_in;
         last_send_time_ff <= last_send_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
      fwd_data_ff <= in_data_ff.write_value;
   end

endmodule

`default_nettype wire

FILE: rtl/tpr_ram.sv
`default_nettype none

module tpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: rtl/tpr_checker.sv
`default_nettype none

module tpr_checker import tpr_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire req_type    req_data,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire rsp_type    rsp_data,
   input wire logic       csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [7:0] csr_wdata
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // no result comes out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an idle transmit slot carries a zero byte
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_byte == 8'd0)
      else $error("byte shown without transmit");

   // no slot without an accepted poll
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.request_valid |-> rsp_data.request_slot == 2'd0)
      else $error("slot shown without poll");

   // an accepted poll sends its first byte at once and turns the line around
   a_poll_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.request_valid |-> rsp_data.tx_valid && rsp_data.transmitter_on)
      else $error("accepted poll did not start a reply");

endmodule

bind telemetry_poll_responder_core tpr_checker u_tpr_checker (.*);

`default_nettype wire

FILE: tb/tpr_reply_checker.sv
module tpr_reply_checker import tpr_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         outstanding,
   output int         polls_answered,
   output int         bytes_sent
);

   localparam int SLOTS = 4;

   logic [7:0]  slot_id [SLOTS];
   logic [6:0]  slot_len [SLOTS];
   logic [1:0]  rx_pending;
   logic [7:0]  poll_first;
   logic [7:0]  poll_second;
   logic [31:0] wait_start;
   logic        reply_armed;
   logic        on_air;
   logic [1:0]  reply_slot;
   logic [6:0]  bytes_to_go;
   logic [6:0]  read_pos;
   logic [7:0]  checksum;
   logic [31:0] last_tx_us;
   logic [7:0]  message [256];
   rsp_type     replies_due [$];

   function automatic rsp_type predict_reply(input req_type t);
      rsp_type    r;
      logic       poll_hit;
      logic [1:0] hit_slot;
      logic [7:0] v;
      int         s;
      r = '0;
      poll_hit = 1'b0;
      hit_slot = '0;
      case (t.kind)
         KIND_RX: begin
            if (!on_air) begin
               if (rx_pending == 2'd0) poll_first = t.rx_byte;
               else if (rx_pending == 2'd1) poll_second = t.rx_byte;
               if (rx_pending != 2'd3) rx_pending++;
            end
         end
         KIND_WRITE: begin
            message[{t.write_slot, t.write_index}] = t.write_value;
         end
         KIND_TICK: begin
            if (!on_air && rx_pending >= 2'd2) begin
               if (rx_pending != 2'd2) begin
                  rx_pending = '0;
                  wait_start = '0;
               end else if (wait_start == '0) begin
                  wait_start = t.now_us;
               end else if ((t.now_us - wait_start) >= REQUEST_WAIT_US) begin
                  wait_start = '0;
                  rx_pending = '0;
                  if (poll_first == POLL_MARK) begin
                     for (s = 0; s < SLOTS; s++) begin
                        if (!poll_hit && slot_id[s] == poll_second) begin
                           poll_hit = 1'b1;
                           hit_slot = 2'(s);
                        end
                     end
                     if (poll_hit) begin
                        reply_armed = 1'b1;
                        reply_slot = hit_slot;
                        bytes_to_go = ((slot_len[hit_slot] > MAX_MESSAGE_BYTES) ?
                                       7'(MAX_MESSAGE_BYTES) : slot_len[hit_slot]) + 7'd1;
                        read_pos = '0;
                     end
                  end
               end
            end
            if ((on_air || reply_armed) &&
                !(on_air && (t.now_us - last_tx_us) < BYTE_GAP_US)) begin
               on_air = 1'b1;
               reply_armed = 1'b0;
               if (bytes_to_go == '0) begin
                  on_air = 1'b0;
                  checksum = '0;
                  rx_pending = '0;
               end else begin
                  bytes_to_go--;
                  r.tx_valid = 1'b1;
                  if (bytes_to_go != '0) begin
                     v = message[{reply_slot, read_pos[5:0]}];
                     checksum = checksum + v;
                     r.tx_byte = v;
                     if (read_pos < MAX_MESSAGE_BYTES) read_pos++;
                  end else begin
                     r.tx_byte = checksum;
                  end
               end
               last_tx_us = t.now_us;
            end
         end
         default: ;
      endcase
      r.transmitter_on = on_air;
      r.request_valid = poll_hit;
      r.request_slot = poll_hit ? hit_slot : 2'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slot_id[0] = SLOT0_ID_RESET;
         slot_id[1] = SLOT1_ID_RESET;
         slot_id[2] = SLOT2_ID_RESET;
         slot_id[3] = SLOT3_ID_RESET;
         slot_len = '{default: LENGTH_RESET};
         rx_pending = '0;
         poll_first = '0;
         poll_second = '0;
         wait_start = '0;
         reply_armed = 1'b0;
         on_air = 1'b0;
         reply_slot = '0;
         bytes_to_go = '0;
         read_pos = '0;
         checksum = '0;
         last_tx_us = '0;
         replies_due.delete();
         mismatches = 0;
         polls_answered = 0;
         bytes_sent = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected reply transaction at %0t: %p", $time, rsp_data);
            end else begin
               want = replies_due.pop_front();
               if (rsp_data.tx_valid !== want.tx_valid || rsp_data.tx_byte !== want.tx_byte ||
                   rsp_data.transmitter_on !== want.transmitter_on ||
                   rsp_data.request_valid !== want.request_valid ||
                   rsp_data.request_slot !== want.request_slot) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"reply mismatch at %0t: expected tx %b/%h on %b poll %b/%0d,",
                               " got tx %b/%h on %b poll %b/%0d"}, $time,
                              want.tx_valid, want.tx_byte, want.transmitter_on,
                              want.request_valid, want.request_slot,
                              rsp_data.tx_valid, rsp_data.tx_byte, rsp_data.transmitter_on,
                              rsp_data.request_valid, rsp_data.request_slot);
               end
            end
         end
         if (csr_write) begin
            if (csr_index >= CSR_SLOT0_LENGTH) slot_len[csr_index[1:0]] = csr_wdata[6:0];
            else slot_id[csr_index[1:0]] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            want = predict_reply(req_data);
            polls_answered += want.request_valid;
            bytes_sent += want.tx_valid;
            replies_due.push_back(want);
         end
      end
      outstanding <= replies_due.size();
   end

endmodule

FILE: tb/telemetry_poll_responder_core_tb.sv
module telemetry_poll_responder_core_tb;
   import tpr_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int MAX_MESSAGE_BYTES = 64;
   localparam int ITEM_TARGET = 1750;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   int polls_answered;
   int bytes_sent;
   int sent = 0;
   int rsp_hold = 0;
   int rsp_draw;
   bit calm = 1'b0;

   logic [31:0] clock_us = '0;
   logic [7:0]  slot_ids [4];
   logic [6:0]  slot_lens [4];

   telemetry_poll_responder_core i_dut (.*);

   tpr_reply_checker #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .polls_answered (polls_answered),
      .bytes_sent     (bytes_sent)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("run stopped after %0d cycles with %0d replies still due", CYCLE_LIMIT,
               outstanding);
      $display("CHECK FAILED");
      $finish;
   end

   // result side backpressure, drawn again after every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_draw = calm ? 0 : $urandom_range(0, 6);
         rsp_hold <= rsp_draw;
         rsp_stall <= (rsp_draw != 0);
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_hold == 1) begin
         rsp_hold <= 0;
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type noise_req();
      req_type t;
      t.kind = 2'($urandom);
      t.now_us = $urandom;
      t.rx_byte = 8'($urandom);
      t.write_slot = 2'($urandom);
      t.write_index = 6'($urandom);
      t.write_value = 8'($urandom);
      return t;
   endfunction

   function automatic logic [31:0] pick_gap();
      case ($urandom_range(0, 9))
         0, 1: return $urandom_range(0, 2999);
         9: return $urandom_range(3000, 100000);
         default: return $urandom_range(3000, 4700);
      endcase
   endfunction

   task automatic push_txn(input req_type t);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_tick_at(input logic [31:0] stamp);
      req_type t;
      t = noise_req();
      t.kind = KIND_TICK;
      t.now_us = stamp;
      clock_us = stamp;
      push_txn(t);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type t;
      t = noise_req();
      t.kind = KIND_RX;
      t.rx_byte = b;
      push_txn(t);
   endtask

   task automatic send_store(input logic [1:0] slot, input logic [5:0] idx,
                             input logic [7:0] value);
      req_type t;
      t = noise_req();
      t.kind = KIND_WRITE;
      t.write_slot = slot;
      t.write_index = idx;
      t.write_value = value;
      push_txn(t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_slots();
      int s;
      drain();
      csr_write <= 1'b1;
      for (s = 0; s < 4; s++) begin
         csr_index <= CSR_SLOT0_ID + 3'(s);
         csr_wdata <= slot_ids[s];
         @(posedge clock);
      end
      for (s = 0; s < 4; s++) begin
         csr_index <= CSR_SLOT0_LENGTH + 3'(s);
         csr_wdata <= {1'b0, slot_lens[s]};
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   task automatic poll_sensor(input logic [7:0] first, input logic [7:0] second,
                              input int ticks);
      send_byte(first);
      send_byte(second);
      repeat (ticks) begin
         if ($urandom_range(0, 14) == 0) send_byte(8'($urandom));
         send_tick_at(clock_us + pick_gap());
      end
   endtask

   task automatic send_noise();
      req_type t;
      t = noise_req();
      if (t.kind == KIND_TICK) send_tick_at(clock_us + pick_gap());
      else push_txn(t);
   endtask

   initial begin
      int s;
      int idx;
      int len;
      int pick;
      int phase;
      req_type t;
      slot_ids[0] = SLOT0_ID_RESET;
      slot_ids[1] = SLOT1_ID_RESET;
      slot_ids[2] = SLOT2_ID_RESET;
      slot_ids[3] = SLOT3_ID_RESET;
      slot_lens = '{default: LENGTH_RESET};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill every message byte so replies never read an unwritten entry
      for (s = 0; s < 4; s++)
         for (idx = 0; idx < MAX_MESSAGE_BYTES; idx++)
            send_store(2'(s), 6'(idx), 8'($urandom));

      // unused kind with every bit set
      t = '1;
      t.kind = KIND_UNUSED;
      push_txn(t);
      // wrong first byte, a tick at time zero starts no wait, one microsecond short
      send_byte(8'h55);
      send_byte(SLOT0_ID_RESET);
      send_tick_at(32'd0);
      send_tick_at(32'd10);
      send_tick_at(32'd4609);
      send_tick_at(32'd4610);
      // no slot matches
      send_byte(POLL_MARK);
      send_byte(8'h00);
      send_tick_at(32'd20000);
      send_tick_at(32'd25000);
      // three bytes flush
      send_byte(POLL_MARK);
      send_byte(SLOT0_ID_RESET);
      send_byte(8'hFF);
      send_tick_at(32'd30000);
      // wait across the time stamp wrap
      send_byte(POLL_MARK);
      send_byte(8'h01);
      send_tick_at(32'hFFFF_F000);
      send_tick_at(32'h0000_0300);
      // exact wait and byte gap boundaries on slot 3
      send_byte(POLL_MARK);
      send_byte(SLOT3_ID_RESET);
      send_tick_at(32'd1000);
      send_tick_at(32'd5600);
      send_tick_at(32'd8599);
      send_tick_at(32'd8600);

      phase = 0;
      while (sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            slot_ids = '{8'h00, 8'hFF, 8'h00, SLOT0_ID_RESET};
            slot_lens = '{7'd0, 7'd64, 7'd127, 7'd1};
            program_slots();
         end else if (phase > 1 && $urandom_range(0, 1) == 1) begin
            for (s = 0; s < 4; s++) begin
               case ($urandom_range(0, 7))
                  0: slot_ids[s] = 8'h00;
                  1: slot_ids[s] = 8'hFF;
                  2: slot_ids[s] = slot_ids[(s + 3) % 4];
                  default: slot_ids[s] = 8'($urandom);
               endcase
               case ($urandom_range(0, 11))
                  0: slot_lens[s] = 7'd0;
                  1: slot_lens[s] = 7'd64;
                  2: slot_lens[s] = 7'($urandom_range(65, 127));
                  default: slot_lens[s] = 7'($urandom_range(1, 8));
               endcase
            end
            program_slots();
         end else if ($urandom_range(0, 3) == 0) begin
            drain();
         end
         if ($urandom_range(0, 7) == 0) clock_us = $urandom;
         repeat ($urandom_range(2, 6)) begin
            pick = $urandom_range(0, 19);
            s = $urandom_range(0, 3);
            len = (slot_lens[s] > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : slot_lens[s];
            if (pick < 14) begin
               poll_sensor(POLL_MARK, slot_ids[s], len + 8);
            end else if (pick < 16) begin
               poll_sensor(POLL_MARK, 8'($urandom), 4);
            end else if (pick < 17) begin
               poll_sensor(8'($urandom), slot_ids[s], 4);
            end else if (pick < 18) begin
               repeat (3) send_byte(8'($urandom));
               send_tick_at(clock_us + pick_gap());
            end else begin
               repeat ($urandom_range(1, 6)) send_noise();
            end
         end
         phase++;
      end
      calm = 1'b0;
      drain();

      $display("ran %0d transactions over %0d phases of slot settings", sent, phase);
      $display("%0d polls answered, %0d reply bytes compared, %0d mismatches",
               polls_answered, bytes_sent, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
